/* sv/olist_pkg.sv */
// package for the ordered list block: capacity, derived widths,
// operation and status codes
// no dependencies
package olist_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int OP_W   = 2;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int POS_W  = 4;
  localparam int TOT_W  = 5;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
  localparam logic [OP_W-1:0] OP_DUMP   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

endpackage

/* sv/ordered_list_insert_delete.sv */
// ordered list of signed 32-bit values held in one synchronous memory
// depends on olist_pkg

// Keeps up to CAPACITY signed values in order, head at entry 0 of a single
// memory with a registered read. Append writes the tail directly unless
// the list is full and loads its result from the emit state once the output
// register is free. Insert-before-key, delete-by-key and dump walk the
// stored entries one memory read per cycle, a dump only while its output
// is not stalled. A successful insert passes through a tail-write state
// before its result. Insert and delete ripple the entries behind the match
// in the same pass, writing each entry back while the next one is read. A
// dump gives one beat per entry, head first, with last on the final beat,
// and is paced by rsp_stall; an empty list gives one beat with status empty.
// A new request is taken once the previous one has left its final result in
// the output register. Stored entries need no clearing after reset: entries
// at or beyond the count are never read.
module ordered_list_insert_delete (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  output logic                                   req_stall,
  input  logic [olist_pkg::OP_W-1:0]             operation,
  input  logic signed [olist_pkg::DATA_W-1:0]    new_value,
  input  logic signed [olist_pkg::DATA_W-1:0]    match_key,
  output logic                                   rsp_valid,
  input  logic                                   rsp_stall,
  output logic [olist_pkg::STAT_W-1:0]           status,
  output logic signed [olist_pkg::DATA_W-1:0]    item_value,
  output logic [olist_pkg::POS_W-1:0]            item_position,
  output logic [olist_pkg::TOT_W-1:0]            entry_count,
  output logic                                   last
);
  import olist_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_TAIL = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]               state;
  logic [CNT_W-1:0]         count;
  logic [OP_W-1:0]          op_q;
  logic signed [DATA_W-1:0] val_q;
  logic signed [DATA_W-1:0] key_q;
  logic [STAT_W-1:0]        res_q;
  logic                     found;
  logic signed [DATA_W-1:0] carry;
  logic [CNT_W-1:0]         raddr;
  logic                     rd_valid;
  logic [IDX_W-1:0]         rd_idx;

  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rdata;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;

  logic        accept;
  logic        full;
  logic        rsp_free;
  logic        rsp_load;
  logic        proc;
  logic        issue;
  logic        is_last;
  logic        match;
  logic        found_now;
  logic [31:0] pos_ext;
  logic [31:0] cnt_ext;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign full      = (count == CNT_W'(CAPACITY));
  assign rsp_free  = !rsp_valid || !rsp_stall;
  // a dump beat can only be consumed when the output register is free
  assign proc      = (state == S_WALK) && rd_valid && (op_q != OP_DUMP || rsp_free);
  assign issue     = (state == S_WALK) && (!rd_valid || proc) && (raddr < count);
  assign is_last   = ((CNT_W'(rd_idx) + CNT_W'(1)) == count);
  assign match     = (rdata == key_q);
  assign found_now = found || match;
  assign pos_ext   = 32'(rd_idx);
  assign cnt_ext   = 32'(count);
  assign rsp_load  = (proc && op_q == OP_DUMP) || (state == S_EMIT && rsp_free);

  // write port: tail append, ripple during the walk, final tail of an insert
  // reads run ahead of the write address, so the two never hit one address
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[IDX_W-1:0];
    mem_wdata = carry;
    unique case (state)
      S_IDLE: begin
        if (accept && operation == OP_APPEND && !full) begin
          mem_we    = 1'b1;
          mem_wdata = new_value;
        end
      end
      S_WALK: begin
        if (proc && op_q == OP_INSERT) begin
          mem_waddr = rd_idx;
          if (found) begin
            mem_we = 1'b1;
          end else if (match) begin
            mem_we    = 1'b1;
            mem_wdata = val_q;
          end
        end else if (proc && op_q == OP_DELETE && found) begin
          mem_we    = 1'b1;
          mem_waddr = rd_idx - IDX_W'(1);
          mem_wdata = rdata;
        end
      end
      S_TAIL: begin
        mem_we = 1'b1;
      end
      S_EMIT: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rdata <= mem[raddr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_valid  <= 1'b0;
      found     <= 1'b0;
      raddr     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_free) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q     <= operation;
            val_q    <= new_value;
            key_q    <= match_key;
            found    <= 1'b0;
            raddr    <= '0;
            rd_valid <= 1'b0;
            unique case (operation)
              OP_APPEND: begin
                if (full) begin
                  res_q <= ST_FULL;
                end else begin
                  count <= count + CNT_W'(1);
                  res_q <= ST_OK;
                end
                state <= S_EMIT;
              end
              OP_INSERT: begin
                if (full) begin
                  res_q <= ST_FULL;
                  state <= S_EMIT;
                end else if (count == '0) begin
                  res_q <= ST_NOT_FOUND;
                  state <= S_EMIT;
                end else begin
                  state <= S_WALK;
                end
              end
              default: begin
                if (count == '0) begin
                  res_q <= ST_EMPTY;
                  state <= S_EMIT;
                end else begin
                  state <= S_WALK;
                end
              end
            endcase
          end
        end
        S_WALK: begin
          if (issue) begin
            raddr    <= raddr + CNT_W'(1);
            rd_idx   <= raddr[IDX_W-1:0];
            rd_valid <= 1'b1;
          end else if (proc) begin
            rd_valid <= 1'b0;
          end
          if (proc) begin
            if (op_q == OP_INSERT && found_now) begin
              found <= 1'b1;
              carry <= rdata;
            end
            if (op_q == OP_DELETE && match) begin
              found <= 1'b1;
            end
            if (op_q == OP_DUMP) begin
              status        <= ST_OK;
              item_value    <= rdata;
              item_position <= pos_ext[POS_W-1:0];
              entry_count   <= cnt_ext[TOT_W-1:0];
              last          <= is_last;
            end
            if (is_last) begin
              priority if (op_q == OP_DUMP) begin
                state <= S_IDLE;
              end else if (!found_now) begin
                res_q <= ST_NOT_FOUND;
                state <= S_EMIT;
              end else if (op_q == OP_INSERT) begin
                state <= S_TAIL;
              end else begin
                count <= count - CNT_W'(1);
                res_q <= ST_OK;
                state <= S_EMIT;
              end
            end
          end
        end
        S_TAIL: begin
          count <= count + CNT_W'(1);
          res_q <= ST_OK;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (rsp_free) begin
            status        <= res_q;
            item_value    <= '0;
            item_position <= '0;
            entry_count   <= cnt_ext[TOT_W-1:0];
            last          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("request accepted without starting work");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_APPEND && !full) |=>
      count == CNT_W'($past(count) + CNT_W'(1)))
    else $error("append did not grow the list");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && rd_valid) |-> (CNT_W'(rd_idx) < count))
    else $error("walk read beyond the entry count");

endmodule

/* tb/ordered_list_insert_delete_test.sv */
`timescale 1ns / 100ps
// self-checking testbench for ordered_list_insert_delete: directed and random list operations
// with a shadow list predicting every response beat; depends on olist_pkg and the block itself

module ordered_list_insert_delete_test;
  import olist_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    logic [TOT_W-1:0]         count;
    logic                     last;
  } list_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [OP_W-1:0] operation = OP_APPEND;
  logic signed [DATA_W-1:0] new_value = '0;
  logic signed [DATA_W-1:0] match_key = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [STAT_W-1:0] status;
  logic signed [DATA_W-1:0] item_value;
  logic [POS_W-1:0] item_position;
  logic [TOT_W-1:0] entry_count;
  logic last;

  // shadow copy of the list
  logic signed [DATA_W-1:0] list_vals [CAPACITY];
  int list_len = 0;
  list_beat_t pending_beats [$];

  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  bit shrinking = 1'b0;

  ordered_list_insert_delete uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .operation(operation),
    .new_value(new_value),
    .match_key(match_key),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .status(status),
    .item_value(item_value),
    .item_position(item_position),
    .entry_count(entry_count),
    .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void queue_beat(logic [STAT_W-1:0] st, logic signed [DATA_W-1:0] val,
                                     int pos, logic lst);
    list_beat_t b;
    b.status   = st;
    b.value    = val;
    b.position = pos[POS_W-1:0];
    b.count    = list_len[TOT_W-1:0];
    b.last     = lst;
    pending_beats.push_back(b);
  endfunction

  function automatic void apply_operation(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val,
                                          logic signed [DATA_W-1:0] key);
    int hit;
    int i;
    hit = -1;
    for (i = 0; i < list_len; i++)
      if (hit < 0 && list_vals[i] == key) hit = i;
    case (op)
      OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          queue_beat(ST_FULL, '0, 0, 1'b1);
        end else begin
          list_vals[list_len] = val;
          list_len++;
          queue_beat(ST_OK, '0, 0, 1'b1);
        end
      end
      OP_INSERT: begin
        // full check wins over the key search
        if (list_len >= CAPACITY) begin
          queue_beat(ST_FULL, '0, 0, 1'b1);
        end else if (hit < 0) begin
          queue_beat(ST_NOT_FOUND, '0, 0, 1'b1);
        end else begin
          for (i = list_len; i > hit; i--) list_vals[i] = list_vals[i-1];
          list_vals[hit] = val;
          list_len++;
          queue_beat(ST_OK, '0, 0, 1'b1);
        end
      end
      OP_DELETE: begin
        if (list_len == 0) begin
          queue_beat(ST_EMPTY, '0, 0, 1'b1);
        end else if (hit < 0) begin
          queue_beat(ST_NOT_FOUND, '0, 0, 1'b1);
        end else begin
          for (i = hit; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
          queue_beat(ST_OK, '0, 0, 1'b1);
        end
      end
      default: begin
        if (list_len == 0) begin
          queue_beat(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          for (i = 0; i < list_len; i++)
            queue_beat(ST_OK, list_vals[i], i, (i + 1 == list_len));
        end
      end
    endcase
  endfunction

  // response checker
  always @(posedge clk) begin
    list_beat_t exp_b;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected response beat: status %0d value %0d", status, item_value);
        error_count++;
      end else begin
        exp_b = pending_beats.pop_front();
        if (status !== exp_b.status) begin
          $error("status: expected %0d, got %0d", exp_b.status, status);
          error_count++;
        end
        if (item_value !== exp_b.value) begin
          $error("item_value: expected %0d, got %0d", exp_b.value, item_value);
          error_count++;
        end
        if (item_position !== exp_b.position) begin
          $error("item_position: expected %0d, got %0d", exp_b.position, item_position);
          error_count++;
        end
        if (entry_count !== exp_b.count) begin
          $error("entry_count: expected %0d, got %0d", exp_b.count, entry_count);
          error_count++;
        end
        if (last !== exp_b.last) begin
          $error("last: expected %0d, got %0d", exp_b.last, last);
          error_count++;
        end
      end
    end
  end

  task automatic send_item(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val,
                           logic signed [DATA_W-1:0] key);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    operation = op;
    new_value = val;
    match_key = key;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    apply_operation(op, val, key);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3: return $signed(32'($urandom_range(15))) - 8;
      default: return $signed($urandom());
    endcase
  endfunction

  // mostly a key that is held, so searches get past the miss path
  function automatic logic signed [DATA_W-1:0] pick_key();
    if (list_len > 0 && $urandom_range(99) < 75)
      return list_vals[$urandom_range(list_len - 1)];
    return pick_value();
  endfunction

  task automatic test_empty_list();
    send_item(OP_DUMP, '0, '0);
    send_item(OP_DELETE, '0, 32'sd3);
    send_item(OP_INSERT, 32'sd4, 32'sd3);
  endtask

  task automatic test_edge_values();
    send_item(OP_APPEND, 32'sh8000_0000, $signed($urandom()));
    send_item(OP_APPEND, 32'sh7fff_ffff, '1);
    send_item(OP_APPEND, 32'sd0, '0);
    send_item(OP_APPEND, 32'sd0, '0);
    send_item(OP_APPEND, -32'sd1, '0);
    // key at the head
    send_item(OP_INSERT, 32'sd5, 32'sh8000_0000);
    // duplicate key: only the first match counts
    send_item(OP_INSERT, 32'sd7, 32'sd0);
    send_item(OP_INSERT, 32'sd9, 32'sd123);
    send_item(OP_DELETE, '1, 32'sd0);
    send_item(OP_DELETE, '0, 32'sd42);
    send_item(OP_DELETE, '0, -32'sd1);
    send_item(OP_DELETE, '0, 32'sd5);
    send_item(OP_DUMP, '1, '1);
  endtask

  task automatic test_full_under_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req++;
    while (list_len < CAPACITY) send_item(OP_APPEND, pick_value(), pick_value());
    send_item(OP_APPEND, 32'sd11, '0);
    send_item(OP_INSERT, 32'sd12, list_vals[0]);
    send_item(OP_DUMP, '0, '0);
    send_item(OP_DELETE, '0, list_vals[1]);
    send_item(OP_DUMP, '0, '0);
  endtask

  task automatic test_random_ops(int n, int send_pct, int recv_pct);
    int k;
    int roll;
    logic [OP_W-1:0] op;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (k = 0; k < n; k++) begin
      if (list_len == CAPACITY && $urandom_range(99) < 30) shrinking = 1'b1;
      if (list_len == 0) shrinking = 1'b0;
      roll = $urandom_range(99);
      if (roll < 20) op = OP_DUMP;
      else if (!shrinking) op = (roll < 55) ? OP_APPEND : (roll < 85) ? OP_INSERT : OP_DELETE;
      else op = (roll < 30) ? OP_APPEND : (roll < 40) ? OP_INSERT : OP_DELETE;
      send_item(op, pick_value(), pick_key());
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;
    test_empty_list();
    test_edge_values();
    test_full_under_backpressure();
    test_random_ops(46, 20, 54);
    test_random_ops(46, 54, 20);
    test_random_ops(45, 0, 0);
    @(negedge clk);
    req_valid = 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_beats.size() != 0) begin
      $error("%0d expected response beats never arrived", pending_beats.size());
      error_count++;
    end
    if (error_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
